// File: rtl/msd_pkg.sv
`default_nettype none
package msd_pkg;

  localparam int DEF_FRAC_BITS = 16;
  localparam int CFG_IDX_W     = 4;
  localparam int PC_W          = 7;
  localparam int PROG_LEN      = 125;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MASS        = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING_X   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING_Y   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING_Z   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS_X = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS_Y = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS_Z = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_METHOD      = 4'd7;

  // method codes
  localparam logic [2:0] M_EULER    = 3'd0;
  localparam logic [2:0] M_IMPLICIT = 3'd1;
  localparam logic [2:0] M_CN       = 3'd2;
  localparam logic [2:0] M_RK2      = 3'd3;
  localparam logic [2:0] M_RK4      = 3'd4;
  localparam logic [2:0] M_HOLD     = 3'd5;

  // operand codes: fixed inputs below 8, scratch memory from 8
  localparam logic [3:0] R_X   = 4'd0;
  localparam logic [3:0] R_V   = 4'd1;
  localparam logic [3:0] R_F   = 4'd2;
  localparam logic [3:0] R_C   = 4'd3;
  localparam logic [3:0] R_K   = 4'd4;
  localparam logic [3:0] R_M   = 4'd5;
  localparam logic [3:0] R_DT  = 4'd6;
  localparam logic [3:0] R_ONE = 4'd7;
  localparam logic [3:0] T0    = 4'd8;
  localparam logic [3:0] T1    = 4'd9;
  localparam logic [3:0] T2    = 4'd10;
  localparam logic [3:0] T3    = 4'd11;
  localparam logic [3:0] T4    = 4'd12;
  localparam logic [3:0] T5    = 4'd13;
  localparam logic [3:0] T6    = 4'd14;
  localparam logic [3:0] T7    = 4'd15;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_HALF, OP_QUART, OP_SIXTH, OP_OUT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [3:0] d;
    logic [3:0] a;
    logic [3:0] b;
  } instr_t;

  typedef struct packed {
    logic        done;
    logic        sat;
    logic [63:0] xn;
    logic [63:0] vn;
  } lane_res_t;

  typedef struct packed {
    logic        sat;
    logic [63:0] val;
  } sat_val_t;

  typedef enum logic [2:0] {
    LS_IDLE, LS_READ, LS_LOAD, LS_ALU, LS_MUL, LS_DIV, LS_FIN, LS_DONE
  } lane_state_t;

  typedef enum logic [1:0] {TS_IDLE, TS_RUN, TS_PUSH} top_state_t;

  function automatic instr_t mk(op_e op, logic [3:0] d, logic [3:0] a, logic [3:0] b);
    instr_t i;
    i.op = op;
    i.d  = d;
    i.a  = a;
    i.b  = b;
    return i;
  endfunction

  // magnitude plus sign back to a saturated 64-bit value
  function automatic sat_val_t from_mag(logic neg, logic hi_nz, logic [63:0] lo);
    sat_val_t   r;
    logic [63:0] lim;
    lim = neg ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    if (hi_nz || lo > lim) begin
      r.sat = 1'b1;
      r.val = neg ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end else begin
      r.sat = 1'b0;
      r.val = neg ? (64'd0 - lo) : lo;
    end
    return r;
  endfunction

  function automatic logic [63:0] mag(logic [63:0] a);
    return a[63] ? (64'd0 - a) : a;
  endfunction

  function automatic logic [PC_W-1:0] start_pc(logic [2:0] method);
    logic [PC_W-1:0] p;
    unique case (method)
      M_EULER: p = 7'd0;
      M_CN:    p = 7'd26;
      M_RK2:   p = 7'd51;
      M_RK4:   p = 7'd72;
      default: p = 7'd10;
    endcase
    return p;
  endfunction

  // a = (f - c*v - k*x) / m appears as five-op groups below
  localparam instr_t PROG [PROG_LEN] = '{
    // explicit Euler
    mk(OP_MUL, T0, R_DT, R_V), mk(OP_ADD, T0, R_X, T0),
    mk(OP_MUL, T1, R_C, R_V), mk(OP_SUB, T1, R_F, T1), mk(OP_MUL, T2, R_K, R_X),
    mk(OP_SUB, T1, T1, T2), mk(OP_DIV, T1, T1, R_M),
    mk(OP_MUL, T1, R_DT, T1), mk(OP_ADD, T1, R_V, T1), mk(OP_OUT, T0, T0, T1),
    // implicit Euler
    mk(OP_MUL, T0, R_DT, R_C), mk(OP_DIV, T0, T0, R_M), mk(OP_ADD, T0, R_ONE, T0),
    mk(OP_MUL, T1, R_DT, R_DT), mk(OP_MUL, T1, T1, R_K), mk(OP_DIV, T1, T1, R_M),
    mk(OP_ADD, T0, T0, T1),
    mk(OP_MUL, T1, R_K, R_X), mk(OP_SUB, T1, R_F, T1), mk(OP_MUL, T1, R_DT, T1),
    mk(OP_DIV, T1, T1, R_M), mk(OP_ADD, T1, R_V, T1), mk(OP_DIV, T1, T1, T0),
    mk(OP_MUL, T2, R_DT, T1), mk(OP_ADD, T2, R_X, T2), mk(OP_OUT, T0, T2, T1),
    // Crank-Nicolson
    mk(OP_MUL, T0, R_K, R_DT), mk(OP_QUART, T0, T0, T0), mk(OP_HALF, T1, R_C, R_C),
    mk(OP_ADD, T0, T1, T0), mk(OP_MUL, T0, R_DT, T0), mk(OP_DIV, T0, T0, R_M),
    mk(OP_ADD, T0, R_ONE, T0),
    mk(OP_MUL, T1, R_C, R_V), mk(OP_HALF, T1, T1, T1), mk(OP_SUB, T1, R_F, T1),
    mk(OP_MUL, T2, R_K, R_X), mk(OP_SUB, T1, T1, T2),
    mk(OP_MUL, T2, R_K, R_DT), mk(OP_MUL, T2, T2, R_V), mk(OP_QUART, T2, T2, T2),
    mk(OP_SUB, T1, T1, T2), mk(OP_MUL, T1, R_DT, T1), mk(OP_DIV, T1, T1, R_M),
    mk(OP_ADD, T1, R_V, T1), mk(OP_DIV, T1, T1, T0),
    mk(OP_ADD, T2, R_V, T1), mk(OP_MUL, T2, R_DT, T2), mk(OP_HALF, T2, T2, T2),
    mk(OP_ADD, T2, R_X, T2), mk(OP_OUT, T0, T2, T1),
    // RK2
    mk(OP_MUL, T0, R_C, R_V), mk(OP_SUB, T0, R_F, T0), mk(OP_MUL, T1, R_K, R_X),
    mk(OP_SUB, T0, T0, T1), mk(OP_DIV, T0, T0, R_M),
    mk(OP_MUL, T1, R_DT, R_V), mk(OP_HALF, T1, T1, T1), mk(OP_ADD, T1, R_X, T1),
    mk(OP_MUL, T2, R_DT, T0), mk(OP_HALF, T2, T2, T2), mk(OP_ADD, T2, R_V, T2),
    mk(OP_MUL, T3, R_DT, T2), mk(OP_ADD, T3, R_X, T3),
    mk(OP_MUL, T4, R_C, T2), mk(OP_SUB, T4, R_F, T4), mk(OP_MUL, T5, R_K, T1),
    mk(OP_SUB, T4, T4, T5), mk(OP_DIV, T4, T4, R_M),
    mk(OP_MUL, T4, R_DT, T4), mk(OP_ADD, T4, R_V, T4), mk(OP_OUT, T0, T3, T4),
    // RK4
    mk(OP_MUL, T0, R_C, R_V), mk(OP_SUB, T0, R_F, T0), mk(OP_MUL, T1, R_K, R_X),
    mk(OP_SUB, T0, T0, T1), mk(OP_DIV, T0, T0, R_M),
    mk(OP_MUL, T1, R_DT, R_V), mk(OP_HALF, T1, T1, T1), mk(OP_ADD, T1, R_X, T1),
    mk(OP_MUL, T2, R_DT, T0), mk(OP_HALF, T2, T2, T2), mk(OP_ADD, T2, R_V, T2),
    mk(OP_MUL, T3, R_C, T2), mk(OP_SUB, T3, R_F, T3), mk(OP_MUL, T1, R_K, T1),
    mk(OP_SUB, T3, T3, T1), mk(OP_DIV, T3, T3, R_M),
    mk(OP_MUL, T1, R_DT, T2), mk(OP_HALF, T1, T1, T1), mk(OP_ADD, T1, R_X, T1),
    mk(OP_MUL, T4, R_DT, T3), mk(OP_HALF, T4, T4, T4), mk(OP_ADD, T4, R_V, T4),
    mk(OP_MUL, T5, R_C, T4), mk(OP_SUB, T5, R_F, T5), mk(OP_MUL, T1, R_K, T1),
    mk(OP_SUB, T5, T5, T1), mk(OP_DIV, T5, T5, R_M),
    mk(OP_MUL, T1, R_DT, T4), mk(OP_ADD, T1, R_X, T1),
    mk(OP_MUL, T6, R_DT, T5), mk(OP_ADD, T6, R_V, T6),
    mk(OP_MUL, T7, R_C, T6), mk(OP_SUB, T7, R_F, T7), mk(OP_MUL, T1, R_K, T1),
    mk(OP_SUB, T7, T7, T1), mk(OP_DIV, T7, T7, R_M),
    mk(OP_ADD, T1, T2, T2), mk(OP_ADD, T1, R_V, T1), mk(OP_ADD, T2, T4, T4),
    mk(OP_ADD, T1, T1, T2), mk(OP_ADD, T1, T1, T6),
    mk(OP_ADD, T2, T3, T3), mk(OP_ADD, T2, T0, T2), mk(OP_ADD, T3, T5, T5),
    mk(OP_ADD, T2, T2, T3), mk(OP_ADD, T2, T2, T7),
    mk(OP_MUL, T1, R_DT, T1), mk(OP_SIXTH, T1, T1, T1), mk(OP_ADD, T1, R_X, T1),
    mk(OP_MUL, T2, R_DT, T2), mk(OP_SIXTH, T2, T2, T2), mk(OP_ADD, T2, R_V, T2),
    mk(OP_OUT, T0, T1, T2)
  };

endpackage
`default_nettype wire

// File: rtl/msd_tick_if.sv
`default_nettype none
interface msd_tick_if;
  logic        valid;
  logic        ready;
  logic [31:0] force_x;
  logic [31:0] force_y;
  logic [31:0] force_z;
  logic [30:0] time_step;

  modport source (output valid, force_x, force_y, force_z, time_step, input ready);
  modport sink   (input valid, force_x, force_y, force_z, time_step, output ready);
endinterface
`default_nettype wire

// File: rtl/msd_result_if.sv
`default_nettype none
interface msd_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] pos_x;
  logic [31:0] pos_y;
  logic [31:0] pos_z;
  logic [31:0] vel_x;
  logic [31:0] vel_y;
  logic [31:0] vel_z;
  logic        overflow;

  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, overflow,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, overflow,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/msd_cfg_if.sv
`default_nettype none
interface msd_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/msd_lane.sv
`default_nettype none
module msd_lane #(
  parameter int FRAC_BITS = msd_pkg::DEF_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [2:0]          method,
  input  logic [31:0]         x,
  input  logic [31:0]         v,
  input  logic [31:0]         f,
  input  logic [31:0]         c,
  input  logic [31:0]         k,
  input  logic [30:0]         m,
  input  logic [30:0]         dt,
  output msd_pkg::lane_res_t  res
);
  import msd_pkg::*;

  lane_state_t       state, state_next;
  logic [PC_W-1:0]   pc;
  instr_t            insn;
  logic [63:0]       tmem [8];
  logic [63:0]       qa, qb;
  logic [63:0]       opa, opb, opa_c, opb_c;
  logic [63:0]       xm, ym;
  logic              neg, dz, dz_c;
  logic [127:0]      acc, dvd, q;
  logic [63:0]       r;
  logic [6:0]        cnt;
  logic [63:0]       xn, vn;
  logic              sat;
  logic [63:0]       pp;
  logic [127:0]      pp_sh;
  logic [64:0]       rr;
  logic              ge;
  logic [64:0]       s65;
  logic [63:0]       tmp, alu_val;
  logic              alu_sat;
  sat_val_t          fin;
  logic              we, wsat;
  logic [63:0]       wd;

  localparam logic [63:0] ONE = 64'd1 << FRAC_BITS;
  // ceil(2^65 / 3): n / 6 == (n * RECIP6) >> 66 for any 64-bit magnitude
  localparam logic [63:0] RECIP6 = 64'hAAAA_AAAA_AAAA_AAAB;

  assign insn = PROG[pc];

  function automatic logic [63:0] pick(logic [3:0] code, logic [63:0] mq);
    logic [63:0] o;
    unique case (code)
      R_X:     o = {{32{x[31]}}, x};
      R_V:     o = {{32{v[31]}}, v};
      R_F:     o = {{32{f[31]}}, f};
      R_C:     o = {{32{c[31]}}, c};
      R_K:     o = {{32{k[31]}}, k};
      R_M:     o = {33'd0, m};
      R_DT:    o = {33'd0, dt};
      R_ONE:   o = ONE;
      default: o = mq;
    endcase
    return o;
  endfunction

  always_comb begin
    opa_c = pick(insn.a, qa);
    opb_c = pick(insn.b, qb);
  end

  assign dz_c  = (insn.op == OP_DIV) && (opb_c == 64'd0);

  // multiply step: one 32x32 partial product per cycle
  always_comb begin
    pp    = (cnt[1] ? xm[63:32] : xm[31:0]) * (cnt[0] ? ym[63:32] : ym[31:0]);
    pp_sh = {64'd0, pp} << {({1'b0, cnt[1]} + {1'b0, cnt[0]}), 5'd0};
  end

  // restoring divide step
  always_comb begin
    rr = {r, dvd[127]};
    ge = rr >= {1'b0, ym};
  end

  // add, subtract, halve, quarter
  always_comb begin
    s65     = '0;
    tmp     = '0;
    alu_val = '0;
    alu_sat = 1'b0;
    unique case (insn.op)
      OP_ADD, OP_SUB: begin
        s65 = (insn.op == OP_ADD) ? ({opa[63], opa} + {opb[63], opb})
                                  : ({opa[63], opa} - {opb[63], opb});
        if (s65[64] != s65[63]) begin
          alu_sat = 1'b1;
          alu_val = s65[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
        end else begin
          alu_val = s65[63:0];
        end
      end
      OP_HALF: begin
        tmp     = opa + {63'd0, opa[63]};
        alu_val = {tmp[63], tmp[63:1]};
      end
      OP_QUART: begin
        tmp     = opa + {62'd0, opa[63], opa[63]};
        alu_val = {{2{tmp[63]}}, tmp[63:2]};
      end
      default: alu_val = '0;
    endcase
  end

  // final rounding and saturation of multiply and divide
  always_comb begin
    if (insn.op == OP_MUL) begin
      fin = from_mag(neg, |acc[127:64+FRAC_BITS], acc[63+FRAC_BITS:FRAC_BITS]);
    end else if (insn.op == OP_SIXTH) begin
      fin = from_mag(neg, 1'b0, {2'b00, acc[127:66]});
    end else if (dz) begin
      fin.sat = (opa != 64'd0);
      fin.val = (opa == 64'd0) ? 64'd0 :
                (opa[63] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}});
    end else begin
      fin = from_mag(neg, |q[127:64], q[63:0]);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      LS_IDLE, LS_DONE: if (start) state_next = LS_READ;
      LS_READ:          state_next = LS_LOAD;
      LS_LOAD: begin
        unique case (insn.op)
          OP_MUL, OP_SIXTH: state_next = LS_MUL;
          OP_DIV:           state_next = dz_c ? LS_FIN : LS_DIV;
          OP_OUT:           state_next = LS_DONE;
          default:          state_next = LS_ALU;
        endcase
      end
      LS_ALU:  state_next = LS_READ;
      LS_MUL:  if (cnt[1:0] == 2'd3) state_next = LS_FIN;
      LS_DIV:  if (cnt == 7'd127) state_next = LS_FIN;
      LS_FIN:  state_next = LS_READ;
      default: state_next = LS_IDLE;
    endcase
  end

  always_comb begin
    we   = (state == LS_ALU) || (state == LS_FIN);
    wd   = (state == LS_ALU) ? alu_val : fin.val;
    wsat = (state == LS_ALU) ? alu_sat : fin.sat;
    res.done = (state == LS_DONE);
    res.sat  = sat;
    res.xn   = xn;
    res.vn   = vn;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // scratch store
  always_ff @(posedge clk) begin
    if (we) begin
      tmem[insn.d[2:0]] <= wd;
    end
    qa <= tmem[insn.a[2:0]];
    qb <= tmem[insn.b[2:0]];
  end

  always_ff @(posedge clk) begin
    if ((state == LS_IDLE || state == LS_DONE) && start) begin
      pc  <= start_pc(method);
      sat <= 1'b0;
    end
    if (we) begin
      sat <= sat | wsat;
      pc  <= pc + 7'd1;
    end
    unique case (state)
      LS_LOAD: begin
        opa <= opa_c;
        opb <= opb_c;
        xm  <= mag(opa_c);
        ym  <= (insn.op == OP_SIXTH) ? RECIP6 : mag(opb_c);
        neg <= (insn.op == OP_SIXTH) ? opa_c[63] : (opa_c[63] ^ opb_c[63]);
        dvd <= {64'd0, mag(opa_c)} << FRAC_BITS;
        acc <= '0;
        r   <= '0;
        q   <= '0;
        cnt <= '0;
        dz  <= dz_c;
        if (insn.op == OP_OUT) begin
          xn <= opa_c;
          vn <= opb_c;
        end
      end
      LS_MUL: begin
        acc <= acc + pp_sh;
        cnt <= cnt + 7'd1;
      end
      LS_DIV: begin
        dvd <= {dvd[126:0], 1'b0};
        r   <= ge ? 64'(rr - {1'b0, ym}) : rr[63:0];
        q   <= {q[126:0], ge};
        cnt <= cnt + 7'd1;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/msd_merge.sv
`default_nettype none
module msd_merge (
  input  msd_pkg::lane_res_t [2:0] lanes,
  output logic                     all_done,
  output logic [2:0][31:0]         pos,
  output logic [2:0][31:0]         vel,
  output logic                     overflow
);
  import msd_pkg::*;

  logic [2:0] sat_x, sat_v;

  function automatic logic [32:0] narrow(logic [63:0] a);
    logic fits;
    fits = (&a[63:31]) || !(|a[63:31]);
    if (fits) return {1'b0, a[31:0]};
    return {1'b1, a[63] ? {1'b1, 31'b0} : {1'b0, {31{1'b1}}}};
  endfunction

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      {sat_x[i], pos[i]} = narrow(lanes[i].xn);
      {sat_v[i], vel[i]} = narrow(lanes[i].vn);
    end
    all_done = lanes[0].done & lanes[1].done & lanes[2].done;
    overflow = (|sat_x) | (|sat_v) | lanes[0].sat | lanes[1].sat | lanes[2].sat;
  end

endmodule
`default_nettype wire

// File: rtl/mass_spring_damper_integrator_top.sv
`default_nettype none
// Hold mode or zero mass skips the lanes; otherwise the three axes run in parallel, each
// lane running the method's program one op at a time, with a shift-add multiplier (also
// used to divide by six) and a bit-serial divider (cut short on a zero divisor).
// Throughput: one tick at a time; the next tick is taken once the result is in the output
// register. Reset (rst, synchronous) zeroes position and velocity, mass = 1.0, method =
// implicit Euler, damping and stiffness = 0.
module mass_spring_damper_integrator_top #(
  parameter int FRAC_BITS = msd_pkg::DEF_FRAC_BITS
) (
  input  logic   clk,
  input  logic   rst,
  msd_tick_if.sink     tick,
  msd_result_if.source result,
  msd_cfg_if.sink      cfg
);
  import msd_pkg::*;

  // configuration
  logic [30:0]       mass;
  logic [2:0][31:0]  damping;
  logic [2:0][31:0]  stiffness;
  logic [2:0]        method;

  // axis state and captured tick
  logic [2:0][31:0]  pos, vel;
  logic [2:0][31:0]  frc;
  logic [30:0]       dt;
  logic              res_ovf;

  // output register
  logic              out_valid;
  logic [2:0][31:0]  opos, ovel;
  logic              oovf;

  top_state_t        state, state_next;
  logic              accept, hold, start, push;

  lane_res_t [2:0]   lanes;
  logic              all_done, movf;
  logic [2:0][31:0]  mpos, mvel;

  assign accept = tick.valid && tick.ready;
  assign hold   = (method == M_HOLD) || (mass == 31'd0);
  assign push   = (state == TS_PUSH) && (!out_valid || result.ready);

  // one lane per axis
  for (genvar i = 0; i < 3; i++) begin : g_lane
    msd_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk    (clk),
      .rst    (rst),
      .start  (start),
      .method (method),
      .x      (pos[i]),
      .v      (vel[i]),
      .f      (frc[i]),
      .c      (damping[i]),
      .k      (stiffness[i]),
      .m      (mass),
      .dt     (dt),
      .res    (lanes[i])
    );
  end

  msd_merge u_merge (
    .lanes    (lanes),
    .all_done (all_done),
    .pos      (mpos),
    .vel      (mvel),
    .overflow (movf)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      TS_IDLE: if (accept) state_next = hold ? TS_PUSH : TS_RUN;
      TS_RUN:  if (all_done) state_next = TS_PUSH;
      TS_PUSH: if (push) state_next = TS_IDLE;
      default: state_next = TS_IDLE;
    endcase
  end

  always_comb begin
    tick.ready = (state == TS_IDLE);
    start      = accept && !hold;
    cfg.ready  = 1'b1;
  end

  assign result.valid    = out_valid;
  assign result.pos_x    = opos[0];
  assign result.pos_y    = opos[1];
  assign result.pos_z    = opos[2];
  assign result.vel_x    = ovel[0];
  assign result.vel_y    = ovel[1];
  assign result.vel_z    = ovel[2];
  assign result.overflow = oovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= TS_IDLE;
      out_valid <= 1'b0;
      pos       <= '0;
      vel       <= '0;
      mass      <= 31'd1 << FRAC_BITS;
      damping   <= '0;
      stiffness <= '0;
      method    <= M_IMPLICIT;
    end else begin
      state <= state_next;
      if (cfg.valid) begin
        unique case (cfg.index)
          REG_MASS:        mass         <= cfg.data[30:0];
          REG_DAMPING_X:   damping[0]   <= cfg.data;
          REG_DAMPING_Y:   damping[1]   <= cfg.data;
          REG_DAMPING_Z:   damping[2]   <= cfg.data;
          REG_STIFFNESS_X: stiffness[0] <= cfg.data;
          REG_STIFFNESS_Y: stiffness[1] <= cfg.data;
          REG_STIFFNESS_Z: stiffness[2] <= cfg.data;
          REG_METHOD:      method       <= cfg.data[2:0];
          default: ;
        endcase
      end
      if (state == TS_RUN && all_done) begin
        pos <= mpos;
        vel <= mvel;
      end
      if (push) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      frc[0]  <= tick.force_x;
      frc[1]  <= tick.force_y;
      frc[2]  <= tick.force_z;
      dt      <= tick.time_step;
      res_ovf <= 1'b0;
    end
    if (state == TS_RUN && all_done) begin
      res_ovf <= movf;
    end
    if (push) begin
      opos <= pos;
      ovel <= vel;
      oovf <= res_ovf;
    end
  end

endmodule
`default_nettype wire
